// ===== hw/rtl/rmt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rmt_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int SLOT_W      = $clog2(TABLE_DEPTH);
   localparam int ADDR_W      = SLOT_W + 1;
   localparam int CNT_W       = 6;
   localparam int CAP_W       = 6;
   localparam int SENDER_W    = 32;
   localparam int TIME_W      = 32;
   localparam int KIND_W      = 8;
   localparam int HANDLE_W    = 16;
   localparam int REQ_W       = 2;
   localparam int STATUS_W    = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 6;

   localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_DEL   = 2'd1;
   localparam logic [REQ_W-1:0] REQ_COUNT = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PER_SNDR = 1'd1;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 6'd10;

   typedef struct packed {
      logic [SENDER_W-1:0] sender;
      logic [TIME_W-1:0]   recv_time;
      logic [TIME_W-1:0]   xmit_time;
      logic [KIND_W-1:0]   kind;
      logic [HANDLE_W-1:0] handle;
   } rec_type;

   typedef struct packed {
      logic              drop_en;
      logic [SLOT_W-1:0] drop_slot;
      logic              ins_en;
      logic [SLOT_W-1:0] ins_slot;
      logic [SLOT_W-1:0] ins_rank;
   } slot_op_type;

   typedef struct packed {
      logic              free_found;
      logic [SLOT_W-1:0] free_slot;
   } slot_stat_type;

endpackage
`default_nettype wire

// ===== hw/rtl/rmt_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface rmt_req_if import rmt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [REQ_W-1:0]    req_type;
   logic [SENDER_W-1:0] sender_id;
   logic [TIME_W-1:0]   recv_time;
   logic [TIME_W-1:0]   xmit_time;
   logic [KIND_W-1:0]   msg_kind;
   logic [HANDLE_W-1:0] msg_handle;

   modport source (output valid, req_type, sender_id, recv_time, xmit_time, msg_kind,
                   msg_handle, input ready);
   modport sink (input valid, req_type, sender_id, recv_time, xmit_time, msg_kind,
                 msg_handle, output ready);
endinterface

interface rmt_rsp_if import rmt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [CNT_W-1:0]    entry_count;
   logic                evicted;
   logic [HANDLE_W-1:0] evicted_handle;

   modport source (output valid, status, entry_count, evicted, evicted_handle,
                   input ready);
   modport sink (input valid, status, entry_count, evicted, evicted_handle,
                 output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rmt_slot_state.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rmt_slot_state import rmt_pkg::*; (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire slot_op_type                        op,
   output logic [TABLE_DEPTH-1:0]                  valid,
   output logic [TABLE_DEPTH-1:0][SLOT_W-1:0]      rank,
   output slot_stat_type                           stat
);

   logic [TABLE_DEPTH-1:0]             valid_ff, valid_in;
   logic [TABLE_DEPTH-1:0][SLOT_W-1:0] rank_ff, rank_in;
   logic [SLOT_W-1:0]                  drop_rank;

   assign drop_rank = rank_ff[op.drop_slot];

   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      if (op.drop_en) begin
         valid_in[op.drop_slot] = 1'b0;
         // close the gap left in the insertion order
         for (int j = 0; j < TABLE_DEPTH; j++) begin
            if (valid_ff[j] && rank_ff[j] > drop_rank) begin
               rank_in[j] = rank_ff[j] - 1'b1;
            end
         end
      end
      if (op.ins_en) begin
         valid_in[op.ins_slot] = 1'b1;
         rank_in[op.ins_slot]  = op.ins_rank;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      rank_ff <= rank_in;
   end

   // lowest free slot
   always_comb begin
      stat.free_found = 1'b0;
      stat.free_slot  = '0;
      for (int j = TABLE_DEPTH - 1; j >= 0; j--) begin
         if (!valid_ff[j]) begin
            stat.free_found = 1'b1;
            stat.free_slot  = SLOT_W'(j);
         end
      end
   end

   assign valid = valid_ff;
   assign rank  = rank_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/recent_message_table.sv =====
`timescale 1ns / 1ps
// After the accepting edge every slot of the slot memory is scanned, then
// the eviction and finish states follow before response valid. Requests
// are taken only in idle, after the last one; the scan through the single
// memory read port sets the pace. A waiting response holds the next finish.
// Reset: synchronous; table empty, capacity 10, per-sender mode off.
`default_nettype none
module recent_message_table import rmt_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   rmt_req_if.sink                    req_bus,
   rmt_rsp_if.source                  rsp_bus,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_EVICT  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   localparam logic [CAP_W-1:0]  CAP_MAX  = CAP_W'(TABLE_DEPTH);
   localparam logic [ADDR_W-1:0] ADDR_END = ADDR_W'(TABLE_DEPTH);

   logic [1:0]          state_ff, state_in;
   logic [CAP_W-1:0]    capacity_ff;
   logic                per_sndr_ff;
   logic [CAP_W-1:0]    cap_eff;

   logic [REQ_W-1:0]    type_ff;
   rec_type             req_rec_ff;
   logic                use_sender_ff;

   logic [ADDR_W-1:0]   addr_ff;
   rec_type             rd_ff;
   rec_type             slot_mem [TABLE_DEPTH];
   logic                mem_we;
   logic [SLOT_W-1:0]   mem_waddr;

   logic [CNT_W-1:0]    cnt_ff;
   logic [CNT_W-1:0]    total_ff;
   logic                best_found_ff;
   logic [SLOT_W-1:0]   best_slot_ff;
   logic [TIME_W-1:0]   best_recv_ff;
   logic [SLOT_W-1:0]   best_rank_ff;
   logic [HANDLE_W-1:0] best_handle_ff;
   logic                evicted_ff;
   logic [HANDLE_W-1:0] ev_handle_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [CNT_W-1:0]    rsp_count_ff;
   logic                rsp_evicted_ff;
   logic [HANDLE_W-1:0] rsp_handle_ff;

   logic [TABLE_DEPTH-1:0]             slot_valid;
   logic [TABLE_DEPTH-1:0][SLOT_W-1:0] slot_rank;
   slot_op_type                        op;
   slot_stat_type                      stat;

   logic                accept;
   logic                proc_en;
   logic [SLOT_W-1:0]   proc_idx;
   logic                proc_valid;
   logic                in_scope;
   logic                better;
   logic                do_evict;
   logic                rsp_free;

   assign cap_eff  = (capacity_ff > CAP_MAX) ? CAP_MAX : capacity_ff;
   assign accept   = req_bus.valid && req_bus.ready;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);

   // slot i is read while addr_ff is i and handled from rd_ff while addr_ff is i+1
   assign proc_en    = (state_ff == ST_SCAN) && (addr_ff != '0);
   assign proc_idx   = addr_ff[SLOT_W-1:0] - 1'b1;
   assign proc_valid = slot_valid[proc_idx];
   assign in_scope   = proc_valid &&
                       (!use_sender_ff || rd_ff.sender == req_rec_ff.sender);
   assign better     = !best_found_ff || rd_ff.recv_time < best_recv_ff ||
                       (rd_ff.recv_time == best_recv_ff &&
                        slot_rank[proc_idx] < best_rank_ff);
   assign do_evict   = (type_ff == REQ_ADD) && (cap_eff != '0) &&
                       (cnt_ff >= cap_eff) && best_found_ff;

   always_comb begin
      op        = '0;
      mem_we    = 1'b0;
      mem_waddr = stat.free_slot;
      if (proc_en && type_ff == REQ_DEL && in_scope) begin
         op.drop_en   = 1'b1;
         op.drop_slot = proc_idx;
      end
      if (state_ff == ST_EVICT && do_evict) begin
         op.drop_en   = 1'b1;
         op.drop_slot = best_slot_ff;
      end
      if (state_ff == ST_FINISH && rsp_free && type_ff == REQ_ADD &&
          cap_eff != '0 && stat.free_found) begin
         op.ins_en    = 1'b1;
         op.ins_slot  = stat.free_slot;
         op.ins_rank  = total_ff[SLOT_W-1:0];
         mem_we       = 1'b1;
      end
   end

   rmt_slot_state u_slot_state (
      .clock (clock),
      .reset (reset),
      .op    (op),
      .valid (slot_valid),
      .rank  (slot_rank),
      .stat  (stat)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= req_rec_ff;
      end
      rd_ff <= slot_mem[addr_ff[SLOT_W-1:0]];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (addr_ff == ADDR_END) begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         capacity_ff  <= CAPACITY_RESET;
         per_sndr_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_CAPACITY: capacity_ff <= csr_wdata[CAP_W-1:0];
               CSR_PER_SNDR: per_sndr_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (state_ff == ST_FINISH && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               type_ff              <= req_bus.req_type;
               req_rec_ff.sender    <= req_bus.sender_id;
               req_rec_ff.recv_time <= req_bus.recv_time;
               req_rec_ff.xmit_time <= req_bus.xmit_time;
               req_rec_ff.kind      <= req_bus.msg_kind;
               req_rec_ff.handle    <= req_bus.msg_handle;
               use_sender_ff        <= (req_bus.req_type != REQ_ADD) || per_sndr_ff;
               addr_ff              <= '0;
               cnt_ff               <= '0;
               total_ff             <= '0;
               best_found_ff        <= 1'b0;
               evicted_ff           <= 1'b0;
               ev_handle_ff         <= '0;
            end
         end
         ST_SCAN: begin
            addr_ff <= addr_ff + 1'b1;
            if (proc_en) begin
               if (proc_valid) begin
                  total_ff <= total_ff + 1'b1;
               end
               if (in_scope) begin
                  cnt_ff <= cnt_ff + 1'b1;
                  if (better) begin
                     best_found_ff  <= 1'b1;
                     best_slot_ff   <= proc_idx;
                     best_recv_ff   <= rd_ff.recv_time;
                     best_rank_ff   <= slot_rank[proc_idx];
                     best_handle_ff <= rd_ff.handle;
                  end
               end
            end
         end
         ST_EVICT: begin
            if (do_evict) begin
               evicted_ff   <= 1'b1;
               ev_handle_ff <= best_handle_ff;
               cnt_ff       <= cnt_ff - 1'b1;
               total_ff     <= total_ff - 1'b1;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_status_ff  <= STATUS_DONE;
               rsp_count_ff   <= '0;
               rsp_evicted_ff <= 1'b0;
               rsp_handle_ff  <= '0;
               case (type_ff)
                  REQ_ADD: begin
                     if (cap_eff == '0) begin
                        rsp_status_ff <= STATUS_IGNORED;
                     end else if (!stat.free_found) begin
                        rsp_status_ff <= STATUS_REFUSED;
                        rsp_count_ff  <= cnt_ff;
                     end else begin
                        rsp_count_ff   <= cnt_ff + 1'b1;
                        rsp_evicted_ff <= evicted_ff;
                        rsp_handle_ff  <= ev_handle_ff;
                     end
                  end
                  REQ_DEL, REQ_COUNT: begin
                     rsp_count_ff <= cnt_ff;
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = rsp_status_ff;
   assign rsp_bus.entry_count    = rsp_count_ff;
   assign rsp_bus.evicted        = rsp_evicted_ff;
   assign rsp_bus.evicted_handle = rsp_handle_ff;

endmodule
`default_nettype wire
